// ----- rtl/bfa_pkg.sv -----
package bfa_pkg;

    localparam int BITMAP_WORDS = 2048;
    localparam int WORD_BITS    = 32;
    localparam int RUN_WORDS    = 32;

    localparam int ADDR_W   = $clog2(BITMAP_WORDS);
    localparam int OFF_W    = $clog2(WORD_BITS);
    localparam int FRAME_W  = 16;
    localparam int FWORD_W  = FRAME_W - OFF_W;
    localparam int CFG_W    = 17;
    localparam int FUNC_W   = 3;
    localparam int RUN_W    = $clog2(RUN_WORDS + 1);
    localparam int CAPACITY = BITMAP_WORDS * WORD_BITS;

    localparam logic [CFG_W-1:0]     FRAMES_RESET = CFG_W'(65536);
    localparam logic [WORD_BITS-1:0] WORD_FULL    = {WORD_BITS{1'b1}};

    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR      = 3'd0,
        FN_SET        = 3'd1,
        FN_TEST       = 3'd2,
        FN_CLEAR_RNG  = 3'd3,
        FN_SET_RNG    = 3'd4,
        FN_FIRST_FREE = 3'd5,
        FN_FREE_RUN   = 3'd6
    } t_func;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK
    } t_state;

    typedef struct packed {
        logic             is_first;
        logic             is_last;
        logic [OFF_W-1:0] lo_off;
        logic [OFF_W-1:0] hi_off;
        logic             set_val;
    } t_word_ctl;

    typedef struct packed {
        logic [WORD_BITS-1:0] new_word;
        logic                 all_zero;
        logic                 free_hit;
        logic [OFF_W-1:0]     free_pos;
    } t_word_res;

endpackage

// ----- rtl/bfa_ram.sv -----
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/bfa_word_unit.sv -----
// Shared per-word unit: range mask update, zero check, lowest free bit at or above lo.
module bfa_word_unit (
    input  logic [bfa_pkg::WORD_BITS-1:0] i_word,
    input  bfa_pkg::t_word_ctl            i_ctl,
    output bfa_pkg::t_word_res            o_res
);
    import bfa_pkg::*;

    logic [OFF_W-1:0]     lo;
    logic [OFF_W-1:0]     hi;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] avail;

    always_comb begin
        lo = i_ctl.is_first ? i_ctl.lo_off : '0;
        hi = i_ctl.is_last  ? i_ctl.hi_off : OFF_W'(WORD_BITS - 1);
        for (int i = 0; i < WORD_BITS; i++) begin
            mask[i]  = (OFF_W'(i) >= lo) && (OFF_W'(i) <= hi);
            avail[i] = ~i_word[i] && (OFF_W'(i) >= lo);
        end

        o_res.new_word = i_ctl.set_val ? (i_word | mask) : (i_word & ~mask);
        o_res.all_zero = (i_word == '0);
        o_res.free_hit = |avail;
        o_res.free_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (avail[i]) begin
                o_res.free_pos = OFF_W'(i);
            end
        end
    end

endmodule

// ----- rtl/bitmap_frame_allocator_unit.sv -----
// Channel   | Signals                                     | Handshake
// ----------+---------------------------------------------+---------------------------------
// request   | i_func, i_first_frame, i_last_frame         | taken when i_start && !o_busy
// result    | o_found_frame, o_frame_used, o_not_found    | o_done, one cycle, no stall
// config    | i_cfg_wr_data (frames_managed)              | i_cfg_wr_en, written at once
//
// After reset the bitmap RAM is filled with ones, one word a cycle, with o_busy held
// high until it is done. Config writes are taken at any time. A request that walks
// N bitmap words (one RAM read port, one word a cycle) reads each word in turn and
// ends with a registered o_done once the last word it needs has been checked.
// Requests that touch no word answer on the next cycle. Results cannot be stalled;
// fields read zero outside o_done.
module bitmap_frame_allocator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [bfa_pkg::FUNC_W-1:0]    i_func,
    input  logic [bfa_pkg::FRAME_W-1:0]   i_first_frame,
    input  logic [bfa_pkg::FRAME_W-1:0]   i_last_frame,
    input  logic                          i_cfg_wr_en,
    input  logic [bfa_pkg::CFG_W-1:0]     i_cfg_wr_data,
    output logic                          o_done,
    output logic [bfa_pkg::FRAME_W-1:0]   o_found_frame,
    output logic                          o_frame_used,
    output logic                          o_not_found
);
    import bfa_pkg::*;

    t_state               r_state, n_state;
    logic [ADDR_W-1:0]    r_clr_addr, n_clr_addr;
    t_func                r_func, n_func;
    logic [FWORD_W-1:0]   r_first_word, n_first_word;
    logic [FWORD_W-1:0]   r_last_word, n_last_word;
    logic [OFF_W-1:0]     r_lo_off, n_lo_off;
    logic [OFF_W-1:0]     r_hi_off, n_hi_off;
    logic [ADDR_W-1:0]    r_rd_addr, n_rd_addr;
    logic [ADDR_W-1:0]    r_end_addr, n_end_addr;
    logic                 r_issue, n_issue;
    logic                 r_pend, n_pend;
    logic [ADDR_W-1:0]    r_pend_addr, n_pend_addr;
    logic [RUN_W-1:0]     r_run, n_run;
    logic [CFG_W-1:0]     r_frames_managed;
    logic                 r_done, n_done;
    logic [FRAME_W-1:0]   r_found_frame, n_found_frame;
    logic                 r_frame_used, n_frame_used;
    logic                 r_not_found, n_not_found;

    logic                 ram_wr_en;
    logic [ADDR_W-1:0]    ram_wr_addr;
    logic [WORD_BITS-1:0] ram_wr_data;
    logic                 ram_rd_en;
    logic [WORD_BITS-1:0] ram_rd_data;

    t_word_ctl            wctl;
    t_word_res            wres;

    t_func                in_func;
    logic [FWORD_W-1:0]   in_first_word;
    logic [FWORD_W-1:0]   in_last_word;
    logic                 in_word_ok;
    logic [CFG_W-1:0]     bound;
    logic [CFG_W-1:0]     bound_m1;
    logic [CFG_W-1:0]     bound_words;
    logic                 take;
    logic                 walk_go;
    logic                 walk_last;
    logic                 search_hit;
    logic                 run_hit;
    logic                 walk_fin;
    logic [31:0]          hit_frame;
    logic [31:0]          run_frame;

    assign in_func       = t_func'(i_func);
    assign in_first_word = i_first_frame[FRAME_W-1:OFF_W];
    assign in_last_word  = i_last_frame[FRAME_W-1:OFF_W];
    assign in_word_ok    = 32'(in_first_word) < BITMAP_WORDS;
    assign bound         = (32'(r_frames_managed) > CAPACITY) ? CFG_W'(CAPACITY)
                                                              : r_frames_managed;
    assign bound_m1      = bound - CFG_W'(1);
    assign bound_words   = bound >> OFF_W;
    assign take          = i_start && !o_busy;

    always_comb begin
        case (in_func)
            FN_CLEAR, FN_SET, FN_TEST: walk_go = in_word_ok;
            FN_CLEAR_RNG, FN_SET_RNG:  walk_go = (i_last_frame >= i_first_frame) && in_word_ok;
            FN_FIRST_FREE:             walk_go = {1'b0, i_first_frame} < bound;
            FN_FREE_RUN:               walk_go = (bound_words != '0);
            default:                   walk_go = 1'b0;
        endcase
    end

    // word unit
    assign wctl.is_first = (32'(r_pend_addr) == 32'(r_first_word));
    assign wctl.is_last  = (32'(r_pend_addr) == 32'(r_last_word));
    assign wctl.lo_off   = r_lo_off;
    assign wctl.hi_off   = r_hi_off;
    assign wctl.set_val  = (r_func == FN_SET) || (r_func == FN_SET_RNG);

    bfa_word_unit u_word (
        .i_word (ram_rd_data),
        .i_ctl  (wctl),
        .o_res  (wres)
    );

    assign hit_frame  = 32'({r_pend_addr, wres.free_pos});
    assign run_frame  = (32'(r_pend_addr) + 32'd1 - 32'(RUN_WORDS)) << OFF_W;
    assign walk_last  = (r_pend_addr == r_end_addr);
    assign search_hit = (r_func == FN_FIRST_FREE) && wres.free_hit
                        && (hit_frame < 32'(bound));
    assign run_hit    = (r_func == FN_FREE_RUN) && wres.all_zero
                        && ((32'(r_run) + 32'd1) >= 32'(RUN_WORDS));
    assign walk_fin   = r_pend && (walk_last || search_hit || run_hit);

    bfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (BITMAP_WORDS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == ADDR_W'(BITMAP_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (take && walk_go) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (walk_fin) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_clr_addr    = r_clr_addr;
        n_func        = r_func;
        n_first_word  = r_first_word;
        n_last_word   = r_last_word;
        n_lo_off      = r_lo_off;
        n_hi_off      = r_hi_off;
        n_rd_addr     = r_rd_addr;
        n_end_addr    = r_end_addr;
        n_issue       = r_issue;
        n_pend        = 1'b0;
        n_pend_addr   = r_pend_addr;
        n_run         = r_run;
        n_done        = 1'b0;
        n_found_frame = '0;
        n_frame_used  = 1'b0;
        n_not_found   = 1'b0;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = r_pend_addr;
        ram_wr_data   = wres.new_word;
        ram_rd_en     = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_clr_addr;
                ram_wr_data = WORD_FULL;
                n_clr_addr  = r_clr_addr + ADDR_W'(1);
            end
            ST_IDLE: begin
                if (take) begin
                    n_func       = in_func;
                    n_first_word = in_first_word;
                    n_lo_off     = i_first_frame[OFF_W-1:0];
                    n_run        = '0;
                    n_issue      = 1'b1;
                    n_rd_addr    = ADDR_W'(in_first_word);
                    n_end_addr   = ADDR_W'(in_first_word);
                    n_last_word  = in_first_word;
                    n_hi_off     = i_first_frame[OFF_W-1:0];
                    case (in_func)
                        FN_CLEAR_RNG, FN_SET_RNG: begin
                            n_last_word = in_last_word;
                            n_hi_off    = i_last_frame[OFF_W-1:0];
                            n_end_addr  = (32'(in_last_word) >= BITMAP_WORDS)
                                          ? ADDR_W'(BITMAP_WORDS - 1)
                                          : ADDR_W'(in_last_word);
                        end
                        FN_FIRST_FREE: begin
                            n_end_addr = ADDR_W'(bound_m1 >> OFF_W);
                        end
                        FN_FREE_RUN: begin
                            n_rd_addr  = '0;
                            n_end_addr = ADDR_W'(bound_words - CFG_W'(1));
                        end
                        default: ;
                    endcase
                    if (!walk_go) begin
                        // nothing to read: answer at once
                        n_issue      = 1'b0;
                        n_done       = 1'b1;
                        n_frame_used = (in_func == FN_TEST);
                        n_not_found  = (in_func == FN_FIRST_FREE) || (in_func == FN_FREE_RUN);
                    end
                end
            end
            ST_WALK: begin
                if (r_issue && !walk_fin) begin
                    ram_rd_en   = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_addr = r_rd_addr;
                    if (r_rd_addr == r_end_addr) begin
                        n_issue = 1'b0;
                    end else begin
                        n_rd_addr = r_rd_addr + ADDR_W'(1);
                    end
                end
                if (r_pend) begin
                    case (r_func)
                        FN_CLEAR, FN_SET, FN_CLEAR_RNG, FN_SET_RNG: ram_wr_en = 1'b1;
                        default: ;
                    endcase
                    n_run = wres.all_zero ? r_run + RUN_W'(1) : '0;
                end
                if (walk_fin) begin
                    n_issue = 1'b0;
                    n_pend  = 1'b0;
                    n_done  = 1'b1;
                    case (r_func)
                        FN_TEST: begin
                            n_frame_used = ram_rd_data[r_lo_off];
                        end
                        FN_FIRST_FREE: begin
                            n_not_found   = !search_hit;
                            n_found_frame = search_hit ? FRAME_W'(hit_frame) : '0;
                        end
                        FN_FREE_RUN: begin
                            n_not_found   = !run_hit;
                            n_found_frame = run_hit ? FRAME_W'(run_frame) : '0;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_CLEAR;
            r_clr_addr       <= '0;
            r_issue          <= 1'b0;
            r_pend           <= 1'b0;
            r_frames_managed <= FRAMES_RESET;
            r_done           <= 1'b0;
            r_found_frame    <= '0;
            r_frame_used     <= 1'b0;
            r_not_found      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_clr_addr    <= n_clr_addr;
            r_issue       <= n_issue;
            r_pend        <= n_pend;
            r_done        <= n_done;
            r_found_frame <= n_found_frame;
            r_frame_used  <= n_frame_used;
            r_not_found   <= n_not_found;
            if (i_cfg_wr_en) begin
                r_frames_managed <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_first_word <= n_first_word;
        r_last_word  <= n_last_word;
        r_lo_off     <= n_lo_off;
        r_hi_off     <= n_hi_off;
        r_rd_addr    <= n_rd_addr;
        r_end_addr   <= n_end_addr;
        r_pend_addr  <= n_pend_addr;
        r_run        <= n_run;
    end

    assign o_busy        = (r_state != ST_IDLE);
    assign o_done        = r_done;
    assign o_found_frame = r_found_frame;
    assign o_frame_used  = r_frame_used;
    assign o_not_found   = r_not_found;

endmodule

// ----- rtl/bfa_checker.sv -----
module bfa_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_start,
    input logic                        o_busy,
    input logic                        o_done,
    input logic [bfa_pkg::FRAME_W-1:0] o_found_frame,
    input logic                        o_frame_used,
    input logic                        o_not_found
);

    // a result lands only once the block is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while busy");

    // a taken request either starts work or answers right away
    a_take_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_done))
        else $error("request taken but dropped");

    a_fields_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_frame_used || o_not_found || (o_found_frame != '0)) |-> o_done)
        else $error("result fields active without strobe");

    a_excl_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_frame_used && o_not_found))
        else $error("test and search flags together");

    a_found_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_found_frame != '0) |-> (!o_not_found && !o_frame_used))
        else $error("found frame with a failure flag");

endmodule

bind bitmap_frame_allocator_unit bfa_checker u_bfa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .o_busy        (o_busy),
    .o_done        (o_done),
    .o_found_frame (o_found_frame),
    .o_frame_used  (o_frame_used),
    .o_not_found   (o_not_found)
);

// ----- test/bitmap_frame_allocator_unit_test.sv -----
module bitmap_frame_allocator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bfa_pkg::*;

    localparam logic [FUNC_W-1:0] FN_UNUSED   = 3'd7;
    localparam int unsigned       CYCLE_LIMIT = 6_000_000;
    localparam int unsigned       PHASE_ITEMS = 46;

    typedef struct packed {
        logic [FRAME_W-1:0] found_frame;
        logic               frame_used;
        logic               not_found;
    } t_frame_answer;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic [FUNC_W-1:0]    i_func;
    logic [FRAME_W-1:0]   i_first_frame;
    logic [FRAME_W-1:0]   i_last_frame;
    logic                 i_cfg_wr_en;
    logic [CFG_W-1:0]     i_cfg_wr_data;
    logic                 o_done;
    logic [FRAME_W-1:0]   o_found_frame;
    logic                 o_frame_used;
    logic                 o_not_found;

    // own copy of the used-frame bitmap and the frame bound
    logic [WORD_BITS-1:0] used_map [BITMAP_WORDS];
    logic [CFG_W-1:0]     frame_bound;

    t_frame_answer        pending_answers [$];
    t_frame_answer        last_answer;
    int unsigned          mismatches    = 0;
    int unsigned          cycle_count   = 0;
    int unsigned          requests_sent = 0;
    bit                   gaps_on       = 1'b1;

    bitmap_frame_allocator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_func        (i_func),
        .i_first_frame (i_first_frame),
        .i_last_frame  (i_last_frame),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_done        (o_done),
        .o_found_frame (o_found_frame),
        .o_frame_used  (o_frame_used),
        .o_not_found   (o_not_found)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d answers pending", cycle_count,
                     pending_answers.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    function automatic t_frame_answer predict_answer(input logic [FUNC_W-1:0] fn,
                                                     input logic [FRAME_W-1:0] lo_frame,
                                                     input logic [FRAME_W-1:0] hi_frame);
        t_frame_answer        ans;
        int unsigned          bound, f, w, words, run_len, lo, hi;
        logic [WORD_BITS-1:0] mask;
        bit                   searching;
        ans   = '0;
        bound = (frame_bound > CAPACITY) ? CAPACITY : frame_bound;
        case (fn)
            FN_CLEAR: used_map[lo_frame >> OFF_W][lo_frame[OFF_W-1:0]] = 1'b0;
            FN_SET:   used_map[lo_frame >> OFF_W][lo_frame[OFF_W-1:0]] = 1'b1;
            FN_TEST:  ans.frame_used = used_map[lo_frame >> OFF_W][lo_frame[OFF_W-1:0]];
            FN_CLEAR_RNG, FN_SET_RNG: begin
                if (hi_frame >= lo_frame) begin
                    for (w = lo_frame >> OFF_W; w <= (hi_frame >> OFF_W); w++) begin
                        lo   = (w == (lo_frame >> OFF_W)) ? lo_frame[OFF_W-1:0] : 0;
                        hi   = (w == (hi_frame >> OFF_W)) ? hi_frame[OFF_W-1:0] : WORD_BITS - 1;
                        mask = (WORD_FULL << lo) & (WORD_FULL >> (WORD_BITS - 1 - hi));
                        if (fn == FN_SET_RNG)
                            used_map[w] = used_map[w] | mask;
                        else
                            used_map[w] = used_map[w] & ~mask;
                    end
                end
            end
            FN_FIRST_FREE: begin
                ans.not_found = 1'b1;
                searching     = 1'b1;
                f             = lo_frame;
                while (searching && f < bound) begin
                    if (used_map[f >> OFF_W] == WORD_FULL) begin
                        f = (f | (WORD_BITS - 1)) + 1;
                    end else if (!used_map[f >> OFF_W][f % WORD_BITS]) begin
                        ans.found_frame = f[FRAME_W-1:0];
                        ans.not_found   = 1'b0;
                        searching       = 1'b0;
                    end else begin
                        f++;
                    end
                end
            end
            FN_FREE_RUN: begin
                ans.not_found = 1'b1;
                words         = bound / WORD_BITS;
                run_len       = 0;
                for (w = 0; w < words && ans.not_found; w++) begin
                    if (used_map[w] != '0) begin
                        run_len = 0;
                    end else begin
                        run_len++;
                        if (run_len >= RUN_WORDS) begin
                            f               = (w + 1 - RUN_WORDS) * WORD_BITS;
                            ans.found_frame = f[FRAME_W-1:0];
                            ans.not_found   = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    // one request: optional gap, then hold start until the block takes it
    task automatic issue_request(input logic [FUNC_W-1:0] fn,
                                 input logic [FRAME_W-1:0] lo_frame,
                                 input logic [FRAME_W-1:0] hi_frame);
        int unsigned gap;
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 99) < 19) begin
            gap     = $urandom_range(1, 6);
            i_start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start       = 1'b1;
        i_func        = fn;
        i_first_frame = lo_frame;
        i_last_frame  = hi_frame;
        do @(posedge i_clk); while (o_busy);
        last_answer = predict_answer(fn, lo_frame, hi_frame);
        pending_answers.push_back(last_answer);
        requests_sent++;
    endtask

    task automatic wait_until_idle();
        @(negedge i_clk);
        i_start = 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_frame_bound(input int unsigned value);
        wait_until_idle();
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        frame_bound = value[CFG_W-1:0];
    endtask

    always @(posedge i_clk) begin
        t_frame_answer want;
        if (i_rst_n && o_done) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = pending_answers.pop_front();
                if (o_found_frame !== want.found_frame)
                    report_mismatch($sformatf("found_frame %0d, expected %0d",
                                              o_found_frame, want.found_frame));
                if (o_frame_used !== want.frame_used)
                    report_mismatch($sformatf("frame_used %b, expected %b",
                                              o_frame_used, want.frame_used));
                if (o_not_found !== want.not_found)
                    report_mismatch($sformatf("not_found %b, expected %b",
                                              o_not_found, want.not_found));
            end
        end
    end

    function automatic logic [FRAME_W-1:0] pick_frame();
        if ($urandom_range(0, 99) < 80)
            return FRAME_W'($urandom_range(0, 4095));
        return FRAME_W'($urandom);
    endfunction

    function automatic logic [FRAME_W-1:0] range_end(input logic [FRAME_W-1:0] lo_frame,
                                                     input int unsigned span);
        if (int'(lo_frame) + span > 65535)
            return '1;
        return FRAME_W'(int'(lo_frame) + span);
    endfunction

    task automatic test_reset_state();
        issue_request(FN_TEST, 16'd0, 16'd0);
        issue_request(FN_FIRST_FREE, 16'd0, 16'hFFFF);
        issue_request(FN_FREE_RUN, 16'hFFFF, 16'd0);
    endtask

    task automatic test_single_frames();
        issue_request(FN_CLEAR, 16'd0, 16'd0);
        issue_request(FN_TEST, 16'd0, 16'hFFFF);
        issue_request(FN_TEST, 16'hFFFF, 16'd0);
        issue_request(FN_CLEAR, 16'hFFFF, 16'hFFFF);
        // frame 0 is free but lies below the start within the same word
        issue_request(FN_FIRST_FREE, 16'd1, 16'd0);
        issue_request(FN_SET, 16'hFFFF, 16'd0);
    endtask

    task automatic test_ranges_and_runs();
        issue_request(FN_CLEAR_RNG, 16'd32, 16'd1055);
        issue_request(FN_FREE_RUN, 16'd0, 16'd0);
        issue_request(FN_FIRST_FREE, 16'd5, 16'd0);
        issue_request(FN_SET_RNG, 16'd40, 16'd40);
        issue_request(FN_FREE_RUN, 16'd0, 16'd0);
        // reversed range leaves the map alone
        issue_request(FN_CLEAR_RNG, 16'd100, 16'd50);
        issue_request(FN_TEST, 16'd50, 16'd0);
        issue_request(FN_SET_RNG, 16'd0, 16'hFFFF);
        issue_request(FN_CLEAR_RNG, 16'd65504, 16'hFFFF);
    endtask

    task automatic test_unused_func();
        issue_request(FN_UNUSED, 16'hFFFF, 16'hFFFF);
        issue_request(FN_UNUSED, 16'd0, 16'd0);
    endtask

    task automatic test_frame_bound();
        set_frame_bound(65504);
        issue_request(FN_FIRST_FREE, 16'd0, 16'd0);
        set_frame_bound(65505);
        issue_request(FN_FIRST_FREE, 16'd0, 16'd0);
        set_frame_bound(0);
        issue_request(FN_FIRST_FREE, 16'd0, 16'd0);
        issue_request(FN_FREE_RUN, 16'd0, 16'd0);
        // bound above capacity clips to the whole bitmap
        set_frame_bound(131071);
        issue_request(FN_FIRST_FREE, 16'd65000, 16'd0);
        issue_request(FN_CLEAR_RNG, 16'd0, 16'd1023);
        set_frame_bound(1024);
        issue_request(FN_FREE_RUN, 16'd0, 16'd0);
        set_frame_bound(1023);
        issue_request(FN_FREE_RUN, 16'd0, 16'd0);
    endtask

    task automatic random_step();
        int unsigned        pick;
        logic [FRAME_W-1:0] a;
        pick = $urandom_range(0, 99);
        a    = pick_frame();
        if (pick < 25) begin
            // allocate: find, mark, confirm
            issue_request(FN_FIRST_FREE, a, FRAME_W'($urandom));
            if (!last_answer.not_found) begin
                a = last_answer.found_frame;
                issue_request(FN_SET, a, FRAME_W'($urandom));
                issue_request(FN_TEST, a, FRAME_W'($urandom));
            end
        end else if (pick < 40) begin
            issue_request(FN_CLEAR, a, FRAME_W'($urandom));
            issue_request(FN_TEST, a, FRAME_W'($urandom));
        end else if (pick < 55) begin
            issue_request(FN_CLEAR_RNG, a, range_end(a, $urandom_range(0, 95)));
        end else if (pick < 65) begin
            issue_request(FN_SET_RNG, a, range_end(a, $urandom_range(0, 95)));
        end else if (pick < 70) begin
            issue_request(FN_FREE_RUN, FRAME_W'($urandom), FRAME_W'($urandom));
            if (!last_answer.not_found && $urandom_range(0, 1)) begin
                a = last_answer.found_frame;
                issue_request(FN_SET_RNG, a, range_end(a, RUN_WORDS * WORD_BITS - 1));
            end
        end else if (pick < 80) begin
            issue_request(FN_TEST, a, FRAME_W'($urandom));
        end else if (pick < 85) begin
            issue_request(FN_SET, a, FRAME_W'($urandom));
        end else if (pick < 90) begin
            issue_request($urandom_range(0, 1) ? FN_SET_RNG : FN_CLEAR_RNG, a,
                          range_end(a, $urandom_range(96, 4095)));
        end else if (pick < 95) begin
            issue_request(FUNC_W'($urandom_range(0, 7)), FRAME_W'($urandom),
                          FRAME_W'($urandom));
        end else begin
            issue_request($urandom_range(0, 1) ? FN_SET_RNG : FN_CLEAR_RNG, a,
                          a - FRAME_W'($urandom_range(1, 64)));
        end
    endtask

    task automatic test_random_traffic();
        int unsigned bounds [11];
        int unsigned p, quota;
        bounds = '{65536, 4096, 1024, 1056, 1023, 32, 33, 1, 0, 131071, 0};
        bounds[10] = $urandom_range(0, 131071);
        for (p = 0; p < 11; p++) begin
            set_frame_bound(bounds[p]);
            gaps_on = (p != 2);
            quota   = requests_sent + PHASE_ITEMS;
            while (requests_sent < quota) random_step();
        end
        gaps_on = 1'b1;
        set_frame_bound(FRAMES_RESET);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_func        = '0;
        i_first_frame = '0;
        i_last_frame  = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        for (int i = 0; i < BITMAP_WORDS; i++) used_map[i] = WORD_FULL;
        frame_bound = FRAMES_RESET;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_single_frames();
        test_ranges_and_runs();
        test_unused_func();
        test_frame_bound();
        test_random_traffic();

        wait_until_idle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
